>>> sv/gwp_pkg.sv
package gwp_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int CFG_WIDTH   = 7;
    localparam int IN_WIDTH    = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int APB_WIDTH   = 32;
    localparam int PADDR_WIDTH = 3;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_RD_SELF,
        ST_RD_UP,
        ST_RD_DN,
        ST_RD_LF,
        ST_RD_RT,
        ST_WAIT,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT
    } gwp_state_t;

    typedef struct packed {
        logic load_self;
        logic take_nbr;
    } gwp_unit_ctl_t;

endpackage

>>> sv/gwp_relax_unit.sv
module gwp_relax_unit import gwp_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  gwp_unit_ctl_t          ctl,
    input  logic                   cell_ok,
    input  logic                   top_cell,
    input  logic                   nbr_ok,
    input  logic [VALUE_WIDTH-1:0] rd_cell,
    input  logic [VALUE_WIDTH-1:0] rd_best,
    output logic [VALUE_WIDTH-1:0] self_best,
    output logic [VALUE_WIDTH-1:0] new_best,
    output logic                   improve
);

    logic [VALUE_WIDTH-1:0] self_cell_reg, self_cell_next;
    logic [VALUE_WIDTH-1:0] self_best_reg, self_best_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] cand;

    always_comb begin
        self_cell_next = self_cell_reg;
        self_best_next = self_best_reg;
        acc_next       = acc_reg;
        if (ctl.load_self) begin
            self_cell_next = cell_ok ? rd_cell : '0;
            self_best_next = rd_best;
            acc_next       = top_cell ? '1 : '0;
        end else if (ctl.take_nbr && nbr_ok && (rd_best > acc_reg)) begin
            acc_next = rd_best;
        end
    end

    always_ff @(posedge aclk) begin
        self_cell_reg <= self_cell_next;
        self_best_reg <= self_best_next;
        acc_reg       <= acc_next;
    end

    assign cand      = (self_cell_reg < acc_reg) ? self_cell_reg : acc_reg;
    assign improve   = cand > self_best_reg;
    assign new_best  = improve ? cand : self_best_reg;
    assign self_best = self_best_reg;

endmodule

>>> sv/grid_widest_path.sv
// grid_widest_path: widest (maximum-bottleneck) path over a 4-connected grid.
// Input channel s_*: one beat per cell in row-major order, s_last_cell on the
// final cell. Grid size comes from the APB registers row_count (0x0) and
// column_count (0x4); 0 acts as 1, values above the maximum act as it.
// Cells beyond rows*cols are dropped; cells not loaded read as zero.
// Loading accepts cells back to back while s_valid is high. After the last cell
// the block clears its score store, then runs relaxation sweeps; for each cell
// it reads itself and its up, down, left and right neighbours in turn through
// the single read port of the score memory, then writes back any gain; sweeps
// repeat until one changes nothing (at least one), and then m_valid rises.
// Output channel m_*: one beat carrying best_bottleneck, held until m_ready.
// s_ready is low from the last cell until the result beat is taken.
// Reset (aresetn low, synchronous) returns to loading with an empty job and
// both registers at 1.
module grid_widest_path import gwp_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [APB_WIDTH-1:0]   pwdata,
    output logic [APB_WIDTH-1:0]   prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [IN_WIDTH-1:0]    s_cell_value,
    input  logic                   s_last_cell,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_WIDTH-1:0]   m_best_bottleneck
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int XW    = (VALUE_WIDTH > IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;
    localparam int KW    = (CFG_WIDTH + 2 > NW) ? CFG_WIDTH + 2 : NW;

    logic [CFG_WIDTH-1:0] row_count_reg, row_count_next;
    logic [CFG_WIDTH-1:0] col_count_reg, col_count_next;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_ROW_COUNT:    row_count_next = pwdata[CFG_WIDTH-1:0];
                REG_COLUMN_COUNT: col_count_next = pwdata[CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_WIDTH'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_WIDTH'(col_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CFG_WIDTH'(1);
            col_count_reg <= CFG_WIDTH'(1);
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    logic [RW-1:0] rows;
    logic [CW-1:0] cols;
    logic [NW-1:0] used;

    always_comb begin
        if (row_count_reg == '0)
            rows = RW'(1);
        else if (KW'(row_count_reg) > KW'(MAX_ROWS))
            rows = RW'(MAX_ROWS);
        else
            rows = RW'(row_count_reg);
        if (col_count_reg == '0)
            cols = CW'(1);
        else if (KW'(col_count_reg) > KW'(MAX_COLS))
            cols = CW'(MAX_COLS);
        else
            cols = CW'(col_count_reg);
    end

    assign used = NW'(rows) * NW'(cols);

    gwp_state_t state_reg, state_next;
    logic [NW-1:0] load_cnt_reg, load_cnt_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic          changed_reg, changed_next;
    logic          cell_ok_reg, top_reg, nbr_ok_reg;

    logic          in_fire, last_idx;
    logic          rd_en, wr_en, cell_wr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data, in_sat;
    logic [XW-1:0] in_ext, vmax_ext;
    logic          nbr_ok_next;
    gwp_unit_ctl_t unit_ctl;
    logic [VALUE_WIDTH-1:0] self_best, new_best;
    logic          improve;

    logic [VALUE_WIDTH-1:0] cell_mem [CELLS];
    logic [VALUE_WIDTH-1:0] best_mem [CELLS];
    logic [VALUE_WIDTH-1:0] cell_q_reg, best_q_reg;

    assign in_fire  = s_valid && s_ready;
    assign last_idx = (idx_reg == used - NW'(1));
    assign in_ext   = XW'(s_cell_value);
    assign vmax_ext = XW'({VALUE_WIDTH{1'b1}});
    assign in_sat   = (in_ext > vmax_ext) ? vmax_ext[VALUE_WIDTH-1:0]
                                          : in_ext[VALUE_WIDTH-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:    if (in_fire && s_last_cell) state_next = ST_CLEAR;
            ST_CLEAR:   if (last_idx) state_next = ST_RD_SELF;
            ST_RD_SELF: state_next = ST_RD_UP;
            ST_RD_UP:   state_next = ST_RD_DN;
            ST_RD_DN:   state_next = ST_RD_LF;
            ST_RD_LF:   state_next = ST_RD_RT;
            ST_RD_RT:   state_next = ST_WAIT;
            ST_WAIT:    state_next = ST_WRITE;
            ST_WRITE: begin
                if (!last_idx)
                    state_next = ST_RD_SELF;
                else if (changed_reg || improve)
                    state_next = ST_RD_SELF;
                else
                    state_next = ST_OUT_RD;
            end
            ST_OUT_RD:  state_next = ST_OUT;
            ST_OUT:     if (m_ready) state_next = ST_LOAD;
            default:    state_next = ST_LOAD;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = '0;
        nbr_ok_next = 1'b0;
        unit_ctl    = '0;
        case (state_reg)
            ST_LOAD:    s_ready = 1'b1;
            ST_CLEAR:   wr_en = 1'b1;
            ST_RD_SELF: rd_en = 1'b1;
            ST_RD_UP: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg - NW'(cols));
                nbr_ok_next = (r_reg != '0);
                unit_ctl.load_self = 1'b1;
            end
            ST_RD_DN: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg + NW'(cols));
                nbr_ok_next = (r_reg + RW'(1) < rows);
                unit_ctl.take_nbr = 1'b1;
            end
            ST_RD_LF: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg - NW'(1));
                nbr_ok_next = (c_reg != '0);
                unit_ctl.take_nbr = 1'b1;
            end
            ST_RD_RT: begin
                rd_en = 1'b1;
                rd_addr = AW'(idx_reg + NW'(1));
                nbr_ok_next = (c_reg + CW'(1) < cols);
                unit_ctl.take_nbr = 1'b1;
            end
            ST_WAIT:    unit_ctl.take_nbr = 1'b1;
            ST_WRITE: begin
                wr_en = improve;
                wr_data = new_best;
            end
            ST_OUT_RD: begin
                rd_en = 1'b1;
                rd_addr = AW'(used - NW'(1));
            end
            ST_OUT:     m_valid = 1'b1;
            default: ;
        endcase
    end

    assign cell_wr = in_fire && (load_cnt_reg < used);

    // counters
    always_comb begin
        load_cnt_next = load_cnt_reg;
        idx_next      = idx_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        changed_next  = changed_reg;
        if (cell_wr)
            load_cnt_next = load_cnt_reg + NW'(1);
        case (state_reg)
            ST_CLEAR: begin
                if (last_idx) begin
                    idx_next = '0;
                    r_next = '0;
                    c_next = '0;
                    changed_next = 1'b0;
                end else begin
                    idx_next = idx_reg + NW'(1);
                end
            end
            ST_WRITE: begin
                if (last_idx) begin
                    idx_next = '0;
                    r_next = '0;
                    c_next = '0;
                    changed_next = 1'b0;
                end else begin
                    idx_next = idx_reg + NW'(1);
                    changed_next = changed_reg || improve;
                    if (c_reg + CW'(1) == cols) begin
                        c_next = '0;
                        r_next = r_reg + RW'(1);
                    end else begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end
            ST_OUT: if (m_ready) load_cnt_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            idx_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            changed_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            idx_reg      <= idx_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            changed_reg  <= changed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_SELF) begin
            cell_ok_reg <= idx_reg < load_cnt_reg;
            top_reg     <= idx_reg == '0;
        end
        nbr_ok_reg <= nbr_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (cell_wr)
            cell_mem[load_cnt_reg[AW-1:0]] <= in_sat;
        if (rd_en)
            cell_q_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            best_mem[wr_addr] <= wr_data;
        if (rd_en)
            best_q_reg <= best_mem[rd_addr];
    end

    gwp_relax_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_relax (
        .aclk     (aclk),
        .ctl      (unit_ctl),
        .cell_ok  (cell_ok_reg),
        .top_cell (top_reg),
        .nbr_ok   (nbr_ok_reg),
        .rd_cell  (cell_q_reg),
        .rd_best  (best_q_reg),
        .self_best(self_best),
        .new_best (new_best),
        .improve  (improve)
    );

    assign m_best_bottleneck = OUT_WIDTH'(best_q_reg);

    a_last_starts_solve: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_cell) |=> (state_reg == ST_CLEAR && !s_ready))
        else $error("last cell did not start the solve");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    a_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (new_best >= self_best))
        else $error("score decreased");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("result repeated");

endmodule
